/* src/rpip_pkg.sv */
// rpip_pkg: shared types, character codes and helper functions for the
// radix-prefixed integer parser. No dependencies.
package rpip_pkg;

    localparam int DATA_W          = 64;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int DIGIT_W         = 5;
    localparam int VALUE_WIDTH_DEF = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNED_MODE = 2'd0,
        CFG_MIN_VALUE   = 2'd1,
        CFG_MAX_VALUE   = 2'd2
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        PH_START       = 6'b000001,
        PH_AFTER_MINUS = 6'b000010,
        PH_AFTER_ZERO  = 6'b000100,
        PH_NEED_DIGIT  = 6'b001000,
        PH_DIGITS      = 6'b010000,
        PH_DEAD        = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    // parser control state carried between step, check and top
    typedef struct packed {
        phase_t phase;
        radix_t radix;
        logic   overflowed;
        logic   negative;
        logic   invalid;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:      PH_START,
        radix:      RX_DEC,
        overflowed: 1'b0,
        negative:   1'b0,
        invalid:    1'b0
    };

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_O_LO  = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_B_LO  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd31;

    function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        begin
            t = CHAR_W'(NO_DIGIT);
            if (c >= CH_0 && c <= CH_9) begin
                t = c - CH_0;
            end else if (c >= CH_A_LO && c <= CH_F_LO) begin
                t = c - CH_A_LO + 8'd10;
            end else if (c >= CH_A_UP && c <= CH_F_UP) begin
                t = c - CH_A_UP + 8'd10;
            end
            return t[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic [DIGIT_W-1:0] radix_val(input radix_t r);
        logic [DIGIT_W-1:0] v;
        begin
            unique case (r)
                RX_DEC: v = 5'd10;
                RX_HEX: v = 5'd16;
                RX_OCT: v = 5'd8;
                RX_BIN: v = 5'd2;
                default: v = 5'd10;
            endcase
            return v;
        end
    endfunction

endpackage

/* src/rpip_step.sv */
// rpip_step: next-state logic for one text character (prefix, sign and
// digit accumulation with overflow detect). Depends on rpip_pkg.
module rpip_step #(
    parameter int VALUE_WIDTH = rpip_pkg::VALUE_WIDTH_DEF
) (
    input  rpip_pkg::ctl_t                  ctl_cur,
    input  logic [VALUE_WIDTH-1:0]          acc_cur,
    input  logic [rpip_pkg::CHAR_W-1:0]     char_code,
    input  logic                            signed_mode,
    output rpip_pkg::ctl_t                  ctl_nxt,
    output logic [VALUE_WIDTH-1:0]          acc_nxt
);

    localparam int PW = VALUE_WIDTH + rpip_pkg::DIGIT_W;

    logic [rpip_pkg::DIGIT_W-1:0] dig;
    logic [rpip_pkg::DIGIT_W-1:0] rad;
    logic                         is_dec;
    logic                         first_dig;
    logic [PW-1:0]                mul_in;
    logic [PW-1:0]                prod;
    logic                         add_ovf;

    assign dig    = rpip_pkg::digit_val(char_code);
    assign rad    = rpip_pkg::radix_val(ctl_cur.radix);
    assign is_dec = (char_code >= rpip_pkg::CH_0) && (char_code <= rpip_pkg::CH_9);

    // first digit of a run starts from zero
    assign first_dig = (ctl_cur.phase == rpip_pkg::PH_START) ||
                       (ctl_cur.phase == rpip_pkg::PH_AFTER_MINUS) ||
                       (ctl_cur.phase == rpip_pkg::PH_NEED_DIGIT) ||
                       (ctl_cur.phase == rpip_pkg::PH_AFTER_ZERO);
    assign mul_in = first_dig ? '0 : PW'(acc_cur);

    // constant-radix multiply as shifts and adds
    always_comb begin
        unique case (ctl_cur.radix)
            rpip_pkg::RX_DEC: prod = (mul_in << 3) + (mul_in << 1);
            rpip_pkg::RX_HEX: prod = mul_in << 4;
            rpip_pkg::RX_OCT: prod = mul_in << 3;
            rpip_pkg::RX_BIN: prod = mul_in << 1;
            default:          prod = mul_in;
        endcase
        prod = prod + PW'(dig);
    end

    assign add_ovf = |prod[PW-1:VALUE_WIDTH];

    always_comb begin
        logic take_digit;
        take_digit = 1'b0;
        ctl_nxt    = ctl_cur;
        acc_nxt    = acc_cur;
        unique case (ctl_cur.phase)
            rpip_pkg::PH_START, rpip_pkg::PH_AFTER_MINUS: begin
                if (char_code == rpip_pkg::CH_MINUS) begin
                    if (ctl_cur.phase == rpip_pkg::PH_START && signed_mode) begin
                        ctl_nxt.negative = 1'b1;
                        ctl_nxt.phase    = rpip_pkg::PH_AFTER_MINUS;
                    end else begin
                        ctl_nxt.overflowed = 1'b1;
                        ctl_nxt.phase      = rpip_pkg::PH_DEAD;
                    end
                end else if (char_code == rpip_pkg::CH_X_LO ||
                             char_code == rpip_pkg::CH_X_UP ||
                             char_code == rpip_pkg::CH_HASH) begin
                    ctl_nxt.radix = rpip_pkg::RX_HEX;
                    ctl_nxt.phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (char_code == rpip_pkg::CH_0) begin
                    acc_nxt       = '0;
                    ctl_nxt.phase = rpip_pkg::PH_AFTER_ZERO;
                end else if (char_code >= rpip_pkg::CH_1 && char_code <= rpip_pkg::CH_9) begin
                    take_digit = 1'b1;
                end else begin
                    ctl_nxt.invalid = 1'b1;
                    ctl_nxt.phase   = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_AFTER_ZERO: begin
                if (char_code == rpip_pkg::CH_X_LO) begin
                    ctl_nxt.radix = rpip_pkg::RX_HEX;
                    ctl_nxt.phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (char_code == rpip_pkg::CH_O_LO) begin
                    ctl_nxt.radix = rpip_pkg::RX_OCT;
                    ctl_nxt.phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (char_code == rpip_pkg::CH_B_LO) begin
                    ctl_nxt.radix = rpip_pkg::RX_BIN;
                    ctl_nxt.phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (is_dec) begin
                    take_digit = 1'b1;
                end else begin
                    ctl_nxt.invalid = 1'b1;
                    ctl_nxt.phase   = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_NEED_DIGIT: begin
                if (is_dec && dig < rad) begin
                    take_digit = 1'b1;
                end else begin
                    ctl_nxt.invalid = 1'b1;
                    ctl_nxt.phase   = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_DIGITS: begin
                if (dig < rad) begin
                    take_digit = 1'b1;
                end else begin
                    ctl_nxt.invalid = 1'b1;
                    ctl_nxt.phase   = rpip_pkg::PH_DEAD;
                end
            end
            default: begin
            end
        endcase

        if (take_digit) begin
            if (add_ovf) begin
                ctl_nxt.overflowed = 1'b1;
                ctl_nxt.phase      = rpip_pkg::PH_DEAD;
                if (first_dig) begin
                    acc_nxt = '0;
                end
            end else begin
                acc_nxt       = prod[VALUE_WIDTH-1:0];
                ctl_nxt.phase = rpip_pkg::PH_DIGITS;
            end
        end
    end

endmodule

/* src/rpip_check.sv */
// rpip_check: end-of-text evaluation: syntax status, sign, overflow and
// min/max range check. Depends on rpip_pkg.
module rpip_check #(
    parameter int VALUE_WIDTH = rpip_pkg::VALUE_WIDTH_DEF
) (
    input  rpip_pkg::ctl_t          ctl,
    input  logic [VALUE_WIDTH-1:0]  mag,
    input  logic                    signed_mode,
    input  logic [VALUE_WIDTH-1:0]  min_w,
    input  logic [VALUE_WIDTH-1:0]  max_w,
    output rpip_pkg::status_t       status,
    output logic [VALUE_WIDTH-1:0]  value
);

    logic                   neg_sel;
    logic [VALUE_WIDTH-1:0] res;
    logic                   mag_too_big;
    logic                   out_of_range;

    assign neg_sel = signed_mode && ctl.negative;
    assign res     = neg_sel ? (~mag + VALUE_WIDTH'(1)) : mag;

    // negative magnitude may reach exactly 2^(W-1)
    assign mag_too_big = neg_sel ? (mag[VALUE_WIDTH-1] && |mag[VALUE_WIDTH-2:0])
                                 : mag[VALUE_WIDTH-1];

    always_comb begin
        if (!signed_mode) begin
            out_of_range = (mag < min_w) || (mag > max_w);
        end else begin
            out_of_range = mag_too_big ||
                           ($signed(res) > $signed(max_w)) ||
                           ($signed(res) < $signed(min_w));
        end
    end

    always_comb begin
        priority if (ctl.phase == rpip_pkg::PH_START ||
                     ctl.phase == rpip_pkg::PH_AFTER_MINUS ||
                     ctl.phase == rpip_pkg::PH_NEED_DIGIT) begin
            status = rpip_pkg::ST_INVALID;
        end else if (ctl.overflowed) begin
            status = rpip_pkg::ST_RANGE;
        end else if (ctl.invalid) begin
            status = rpip_pkg::ST_INVALID;
        end else if (out_of_range) begin
            status = rpip_pkg::ST_RANGE;
        end else begin
            status = rpip_pkg::ST_OK;
        end
    end

    assign value = (status == rpip_pkg::ST_OK) ? res : '0;

endmodule

/* src/radix_prefixed_integer_parser.sv */
// Radix-prefixed ASCII integer parser, one character per item, end item closes.
// An accepted end item moves through the input register, then the result register.
// Throughput: one item per cycle unless stalled; a step is one shift-add and compare.
// A pending result stalls the input only when the next registered item is an end item.
// Reset (aresetn low, synchronous): parser at start of text, unsigned mode, min 0,
// max all ones, no item held.
module radix_prefixed_integer_parser #(
    parameter int VALUE_WIDTH = rpip_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rpip_pkg::CHAR_W-1:0]       s_char_code,
    input  logic                              s_is_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rpip_pkg::DATA_W-1:0]       m_value,
    output logic [rpip_pkg::STATUS_W-1:0]     m_status,
    input  logic                              cfg_we,
    input  logic [rpip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpip_pkg::DATA_W-1:0]       cfg_data
);

    logic                            signed_mode_reg;
    logic [rpip_pkg::DATA_W-1:0]     min_value_reg;
    logic [rpip_pkg::DATA_W-1:0]     max_value_reg;

    logic                            in_valid_reg;
    logic [rpip_pkg::CHAR_W-1:0]     in_char_reg;
    logic                            in_end_reg;

    rpip_pkg::ctl_t                  ctl_reg;
    rpip_pkg::ctl_t                  ctl_next;
    logic [VALUE_WIDTH-1:0]          acc_reg;
    logic [VALUE_WIDTH-1:0]          acc_next;

    logic                            out_valid_reg;
    logic [rpip_pkg::DATA_W-1:0]     out_value_reg;
    rpip_pkg::status_t               out_status_reg;

    rpip_pkg::status_t               chk_status;
    logic [VALUE_WIDTH-1:0]          chk_value;

    logic                            out_free;
    logic                            proceed;

    assign out_free = !out_valid_reg || m_ready;
    assign proceed  = in_valid_reg && (!in_end_reg || out_free);
    assign s_ready  = !in_valid_reg || proceed;

    rpip_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
        .ctl_cur     (ctl_reg),
        .acc_cur     (acc_reg),
        .char_code   (in_char_reg),
        .signed_mode (signed_mode_reg),
        .ctl_nxt     (ctl_next),
        .acc_nxt     (acc_next)
    );

    rpip_check #(.VALUE_WIDTH(VALUE_WIDTH)) u_check (
        .ctl         (ctl_reg),
        .mag         (acc_reg),
        .signed_mode (signed_mode_reg),
        .min_w       (min_value_reg[VALUE_WIDTH-1:0]),
        .max_w       (max_value_reg[VALUE_WIDTH-1:0]),
        .status      (chk_status),
        .value       (chk_value)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b0;
            min_value_reg   <= '0;
            max_value_reg   <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rpip_pkg::CFG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                rpip_pkg::CFG_MIN_VALUE:   min_value_reg   <= cfg_data;
                rpip_pkg::CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_end_reg  <= s_is_end;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= rpip_pkg::CTL_RESET;
            acc_reg <= '0;
        end else if (proceed) begin
            if (in_end_reg) begin
                ctl_reg <= rpip_pkg::CTL_RESET;
                acc_reg <= '0;
            end else begin
                ctl_reg <= ctl_next;
                acc_reg <= acc_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && in_end_reg) begin
            out_value_reg  <= rpip_pkg::DATA_W'(chk_value);
            out_status_reg <= chk_status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

`ifndef SYNTH
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(ctl_reg.phase))
        else $error("parser phase not one-hot");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && in_end_reg |=> ctl_reg.phase == rpip_pkg::PH_START && acc_reg == '0)
        else $error("end item did not return parser to start of text");

    a_value_zero_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rpip_pkg::ST_OK |-> m_value == '0)
        else $error("nonzero value with error status");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == rpip_pkg::ST_OK || m_status == rpip_pkg::ST_INVALID ||
                     m_status == rpip_pkg::ST_RANGE))
        else $error("illegal status code");

    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(proceed && in_end_reg))
        else $error("result overwritten while stalled");
`endif

endmodule

/* tb/sv/radix_prefixed_integer_parser_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for radix_prefixed_integer_parser: a queue-fed driver, a monitor and
// a cycle-free predictor of the parsed value and status. Depends on rpip_pkg and the RTL.
module radix_prefixed_integer_parser_tb;

    localparam logic [rpip_pkg::DATA_W-1:0] ALL_ONES = '1;
    localparam logic [rpip_pkg::DATA_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [rpip_pkg::DATA_W-1:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [rpip_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 77;

    typedef struct {
        logic [rpip_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_item_t;

    typedef struct {
        logic [rpip_pkg::DATA_W-1:0] value;
        rpip_pkg::status_t           status;
    } number_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [rpip_pkg::CHAR_W-1:0]    s_char_code = '0;
    logic                           s_is_end = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [rpip_pkg::DATA_W-1:0]    m_value;
    logic [rpip_pkg::STATUS_W-1:0]  m_status;
    logic                           cfg_we = 1'b0;
    logic [rpip_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rpip_pkg::DATA_W-1:0]    cfg_data = '0;

    text_item_t char_stream[$];
    number_t    awaited_numbers[$];
    text_item_t next_item;
    number_t    head;
    int         items_queued = 0;
    int         error_count = 0;
    int         send_gap_max = 0;
    int         recv_stall_max = 0;
    int         send_wait = 0;
    int         recv_wait = 0;

    // register mirror
    logic                        mode_signed = 1'b0;
    logic [rpip_pkg::DATA_W-1:0] lo_bound = '0;
    logic [rpip_pkg::DATA_W-1:0] hi_bound = '1;

    // parse state of the number in flight
    rpip_pkg::phase_t            num_phase = rpip_pkg::PH_START;
    rpip_pkg::radix_t            num_radix = rpip_pkg::RX_DEC;
    logic [rpip_pkg::DATA_W-1:0] num_mag = '0;
    logic                        num_ovf = 1'b0;
    logic                        num_neg = 1'b0;
    logic                        num_bad = 1'b0;

    radix_prefixed_integer_parser dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_code(s_char_code),
        .s_is_end   (s_is_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_status   (m_status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [4:0] base_of(rpip_pkg::radix_t r);
        case (r)
            rpip_pkg::RX_HEX: return 5'd16;
            rpip_pkg::RX_OCT: return 5'd8;
            rpip_pkg::RX_BIN: return 5'd2;
            default: return 5'd10;
        endcase
    endfunction

    function automatic int unsigned char_weight(logic [rpip_pkg::CHAR_W-1:0] c);
        if (c >= rpip_pkg::CH_0 && c <= rpip_pkg::CH_9)
            return 32'(c - rpip_pkg::CH_0);
        if (c >= rpip_pkg::CH_A_LO && c <= rpip_pkg::CH_F_LO)
            return 32'(c - rpip_pkg::CH_A_LO) + 10;
        if (c >= rpip_pkg::CH_A_UP && c <= rpip_pkg::CH_F_UP)
            return 32'(c - rpip_pkg::CH_A_UP) + 10;
        return 99;
    endfunction

    function automatic void accumulate_digit(int unsigned d);
        logic [rpip_pkg::DATA_W-1:0] base;
        base = rpip_pkg::DATA_W'(base_of(num_radix));
        if (num_mag > (ALL_ONES - rpip_pkg::DATA_W'(d)) / base) begin
            num_ovf = 1'b1;
            num_phase = rpip_pkg::PH_DEAD;
        end else begin
            num_mag = num_mag * base + rpip_pkg::DATA_W'(d);
            num_phase = rpip_pkg::PH_DIGITS;
        end
    endfunction

    function automatic void feed_char(logic [rpip_pkg::CHAR_W-1:0] c);
        int unsigned d;
        d = char_weight(c);
        case (num_phase)
            rpip_pkg::PH_START, rpip_pkg::PH_AFTER_MINUS: begin
                if (c == rpip_pkg::CH_MINUS) begin
                    if (num_phase == rpip_pkg::PH_START && mode_signed) begin
                        num_neg = 1'b1;
                        num_phase = rpip_pkg::PH_AFTER_MINUS;
                    end else begin
                        num_ovf = 1'b1;
                        num_phase = rpip_pkg::PH_DEAD;
                    end
                end else if (c == rpip_pkg::CH_X_LO || c == rpip_pkg::CH_X_UP ||
                             c == rpip_pkg::CH_HASH) begin
                    num_radix = rpip_pkg::RX_HEX;
                    num_phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (c == rpip_pkg::CH_0) begin
                    num_mag = '0;
                    num_phase = rpip_pkg::PH_AFTER_ZERO;
                end else if (c >= rpip_pkg::CH_1 && c <= rpip_pkg::CH_9) begin
                    num_mag = '0;
                    accumulate_digit(d);
                end else begin
                    num_bad = 1'b1;
                    num_phase = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_AFTER_ZERO: begin
                if (c == rpip_pkg::CH_X_LO) begin
                    num_radix = rpip_pkg::RX_HEX;
                    num_phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (c == rpip_pkg::CH_O_LO) begin
                    num_radix = rpip_pkg::RX_OCT;
                    num_phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (c == rpip_pkg::CH_B_LO) begin
                    num_radix = rpip_pkg::RX_BIN;
                    num_phase = rpip_pkg::PH_NEED_DIGIT;
                end else if (c >= rpip_pkg::CH_0 && c <= rpip_pkg::CH_9) begin
                    accumulate_digit(d);
                end else begin
                    num_bad = 1'b1;
                    num_phase = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_NEED_DIGIT: begin
                if (c >= rpip_pkg::CH_0 && c <= rpip_pkg::CH_9 &&
                        d < 32'(base_of(num_radix))) begin
                    num_mag = '0;
                    accumulate_digit(d);
                end else begin
                    num_bad = 1'b1;
                    num_phase = rpip_pkg::PH_DEAD;
                end
            end
            rpip_pkg::PH_DIGITS: begin
                if (d < 32'(base_of(num_radix))) begin
                    accumulate_digit(d);
                end else begin
                    num_bad = 1'b1;
                    num_phase = rpip_pkg::PH_DEAD;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void close_number();
        logic [rpip_pkg::DATA_W-1:0] res;
        logic [rpip_pkg::DATA_W-1:0] neg;
        rpip_pkg::status_t           st;
        res = '0;
        st = rpip_pkg::ST_OK;
        neg = '0 - num_mag;
        if (num_phase == rpip_pkg::PH_START || num_phase == rpip_pkg::PH_AFTER_MINUS ||
                num_phase == rpip_pkg::PH_NEED_DIGIT) begin
            st = rpip_pkg::ST_INVALID;
        end else if (num_ovf) begin
            st = rpip_pkg::ST_RANGE;
        end else if (num_bad) begin
            st = rpip_pkg::ST_INVALID;
        end else if (!mode_signed) begin
            if (num_mag < lo_bound || num_mag > hi_bound) st = rpip_pkg::ST_RANGE;
            else res = num_mag;
        end else if (!num_neg) begin
            if (num_mag > MAX_POS || $signed(num_mag) > $signed(hi_bound)
                    || $signed(num_mag) < $signed(lo_bound)) st = rpip_pkg::ST_RANGE;
            else res = num_mag;
        end else begin
            // magnitude may reach 2^63 for the most negative value
            if (num_mag > SIGN_BIT || $signed(neg) > $signed(hi_bound)
                    || $signed(neg) < $signed(lo_bound)) st = rpip_pkg::ST_RANGE;
            else res = neg;
        end
        awaited_numbers.push_back('{res, st});
        num_phase = rpip_pkg::PH_START;
        num_radix = rpip_pkg::RX_DEC;
        num_mag = '0;
        num_ovf = 1'b0;
        num_neg = 1'b0;
        num_bad = 1'b0;
    endfunction

    task automatic flag_mismatch(string what, logic [rpip_pkg::DATA_W-1:0] got,
                                 logic [rpip_pkg::DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // driver: predicts on each accepted item, then presents the next one after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_is_end) close_number();
                else feed_char(s_char_code);
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    s_valid <= 1'b0;
                    send_wait--;
                end else if (char_stream.size() > 0) begin
                    next_item = char_stream.pop_front();
                    s_valid <= 1'b1;
                    s_char_code <= next_item.code;
                    s_is_end <= next_item.last;
                    send_wait = $urandom_range(send_gap_max, 0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result, then holds m_ready low for a random stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_numbers.size() == 0) begin
                    flag_mismatch("unexpected result, value", m_value, '0);
                end else begin
                    head = awaited_numbers.pop_front();
                    if (m_value !== head.value) flag_mismatch("value", m_value, head.value);
                    if (m_status !== head.status)
                        flag_mismatch("status", rpip_pkg::DATA_W'(m_status),
                                      rpip_pkg::DATA_W'(head.status));
                end
                recv_wait = $urandom_range(recv_stall_max, 0);
            end
            if (recv_wait > 0) begin
                m_ready <= 1'b0;
                recv_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_text(input logic [rpip_pkg::CHAR_W-1:0] txt[$]);
        foreach (txt[i]) char_stream.push_back('{txt[i], 1'b0});
        char_stream.push_back('{rpip_pkg::CHAR_W'($urandom_range(255, 0)), 1'b1});
        items_queued += txt.size() + 1;
    endtask

    task automatic send_string(string s);
        logic [rpip_pkg::CHAR_W-1:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        push_text(txt);
    endtask

    task automatic queue_random_text();
        logic [rpip_pkg::CHAR_W-1:0] txt[$];
        logic [rpip_pkg::CHAR_W-1:0] ch;
        rpip_pkg::radix_t            rx;
        int unsigned                 kind;
        int unsigned                 n;
        int unsigned                 base;
        int unsigned                 v;
        bit                          prefixed;
        kind = $urandom_range(99, 0);
        rx = rpip_pkg::RX_DEC;
        prefixed = 1'b0;
        if (kind < 6) begin
            n = $urandom_range(6, 0);
            repeat (n) txt.push_back(rpip_pkg::CHAR_W'($urandom_range(255, 0)));
        end else begin
            if ($urandom_range(mode_signed ? 2 : 11, 0) == 0) txt.push_back(rpip_pkg::CH_MINUS);
            case ($urandom_range(7, 0))
                3: begin
                    txt.push_back(rpip_pkg::CH_X_LO);
                    rx = rpip_pkg::RX_HEX;
                    prefixed = 1'b1;
                end
                4: begin
                    txt.push_back(rpip_pkg::CH_X_UP);
                    rx = rpip_pkg::RX_HEX;
                    prefixed = 1'b1;
                end
                5: begin
                    txt.push_back(rpip_pkg::CH_HASH);
                    rx = rpip_pkg::RX_HEX;
                    prefixed = 1'b1;
                end
                6: begin
                    txt.push_back(rpip_pkg::CH_0);
                    rx = rpip_pkg::radix_t'($urandom_range(3, 1));
                    txt.push_back(rx == rpip_pkg::RX_HEX ? rpip_pkg::CH_X_LO :
                                  rx == rpip_pkg::RX_OCT ? rpip_pkg::CH_O_LO :
                                                           rpip_pkg::CH_B_LO);
                    prefixed = 1'b1;
                end
                7: txt.push_back(rpip_pkg::CH_0);
                default: ;
            endcase
            base = 32'(base_of(rx));
            if ($urandom_range(9, 0) == 0)
                n = $urandom_range(rx == rpip_pkg::RX_BIN ? 70 : 24, 10);
            else n = $urandom_range(4, 1);
            if (kind < 12) n = 0;
            for (int i = 0; i < n; i++) begin
                // a prefix must be followed by a decimal digit
                v = (i == 0 && prefixed && base > 10) ? $urandom_range(9, 0)
                                                      : $urandom_range(base - 1, 0);
                if (v < 10) ch = rpip_pkg::CHAR_W'(rpip_pkg::CH_0 + v);
                else ch = rpip_pkg::CHAR_W'(($urandom_range(1, 0) ? rpip_pkg::CH_A_LO
                                                                  : rpip_pkg::CH_A_UP)
                                            + v - 10);
                txt.push_back(ch);
            end
            if (kind < 22 && txt.size() > 0) begin
                txt[$urandom_range(txt.size() - 1, 0)] =
                    rpip_pkg::CHAR_W'($urandom_range(255, 0));
            end else if (kind < 28) begin
                txt.insert($urandom_range(txt.size(), 0), rpip_pkg::CH_MINUS);
            end
        end
        push_text(txt);
    endtask

    task automatic write_reg(input logic [rpip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpip_pkg::DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rpip_pkg::CFG_SIGNED_MODE: mode_signed = data[0];
            rpip_pkg::CFG_MIN_VALUE:   lo_bound = data;
            rpip_pkg::CFG_MAX_VALUE:   hi_bound = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(logic sgn, logic [rpip_pkg::DATA_W-1:0] lo,
                               logic [rpip_pkg::DATA_W-1:0] hi);
        write_reg(rpip_pkg::CFG_SIGNED_MODE, {{(rpip_pkg::DATA_W-1){1'b0}}, sgn});
        write_reg(rpip_pkg::CFG_MIN_VALUE, lo);
        write_reg(rpip_pkg::CFG_MAX_VALUE, hi);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (char_stream.size() != 0 || s_valid || awaited_numbers.size() != 0)
            @(negedge aclk);
        // trailing characters may still sit in the pipeline
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: unsigned, full range
        send_gap_max = 8;
        recv_stall_max = 8;
        send_string("");
        send_string("0");
        send_string("007");
        send_string("18446744073709551615");
        send_string("18446744073709551616");
        send_string("0xffffffffffffffff");
        send_string("x1F");
        send_string("X0");
        send_string("#7");
        send_string("0o17");
        send_string("0b101");
        send_string("-5");
        send_string("x0x1");
        send_string("0x");
        send_string("xA");
        send_string("12z");
        send_string("0o8");
        send_string("0b2");
        send_string("0X1");
        send_string("99999999999999999999z");
        wait_drained();

        apply_setup(1'b1, SIGN_BIT, MAX_POS);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        @(negedge aclk);
        send_gap_max = 0;
        recv_stall_max = 0;
        send_string("-");
        send_string("--1");
        send_string("1-");
        send_string("-0");
        send_string("-9223372036854775808");
        send_string("-9223372036854775809");
        send_string("9223372036854775807");
        send_string("9223372036854775808");
        send_string("-x7F");
        wait_drained();

        items_queued = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_setup(1'b0, '0, ALL_ONES);
                1: apply_setup(1'b1, SIGN_BIT, MAX_POS);
                2: apply_setup(1'b0, 64'd100, 64'd5000);
                3: apply_setup(1'b1, -64'sd1000, 64'd1000);
                4: apply_setup(1'b0, ALL_ONES, '0);
                default: apply_setup(1'b1, SIGN_BIT, ALL_ONES);
            endcase
            send_gap_max = (ph % 3 == 1) ? 0 : 8;
            recv_stall_max = (ph % 2 == 1) ? 0 : 8;
            while (items_queued < (ph + 1) * PHASE_ITEMS) queue_random_text();
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (awaited_numbers.size() != 0)
            flag_mismatch("results never seen, count",
                          rpip_pkg::DATA_W'(awaited_numbers.size()), '0);
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

/* radix_prefixed_integer_parser.f */
src/rpip_pkg.sv
src/rpip_step.sv
src/rpip_check.sv
src/radix_prefixed_integer_parser.sv
tb/sv/radix_prefixed_integer_parser_tb.sv
